[hdl/swirl_texture_remap_core_defines.svh]
// Assertion macros shared by the swirl remap RTL.
`ifndef SWIRL_TEXTURE_REMAP_CORE_DEFINES_SVH
`define SWIRL_TEXTURE_REMAP_CORE_DEFINES_SVH

// Checks an implication on every clock edge outside reset.
`define STEXR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");

// Checks a property in reset too (for invariants that hold from power up).
`define STEXR_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("%m: invariant failed");

`endif

[hdl/stexr_pkg.sv]
// Package: widths, swirl constants, job type and phase/quantizer functions.
`default_nettype none
package stexr_pkg;
	localparam int TEXEL_BITS       = 8;
	localparam int ANIM_PERIOD      = 1024;
	localparam int SIDE_BITS        = 6;
	localparam int INDEX_BITS       = 2 * SIDE_BITS;
	localparam int VALUE_BITS       = 8;
	localparam int TIME_BITS        = 10;
	localparam int PHASE_BITS       = 13;
	localparam int PHASE_RANGE      = 8192;
	localparam int STORE_DEPTH      = 1 << INDEX_BITS;

	localparam int COORD_MUL_LO     = PHASE_RANGE / 64;
	localparam int COORD_MUL_HI     = PHASE_RANGE / 32;
	localparam int TIME_STEP        = 40;
	localparam int TMUL_A           = 5 * TIME_STEP;
	localparam int TMUL_BD          = 4 * TIME_STEP;
	localparam int TMUL_C           = 3 * TIME_STEP;
	localparam int OFS_A            = 900;
	localparam int OFS_B            = 300;
	localparam int OFS_C            = 700;
	localparam int OFS_D            = 1200;
	localparam int SWIRL_BIAS       = 128;

	// quantized sine breakpoints
	localparam int Q_RISE           = 683;
	localparam int Q_PEAK_END       = 3412;
	localparam int Q_HALF_END       = 4095;
	localparam int Q_FALL_END       = 4778;
	localparam int Q_TROUGH_END     = 7508;

	localparam int QDEPTH           = 4;
	localparam int QPTR_BITS        = $clog2(QDEPTH);
	localparam int QCNT_BITS        = QPTR_BITS + 1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} stexr_op_t;

	typedef struct packed {
		stexr_op_t               op;
		logic [INDEX_BITS-1:0]   addr;
		logic [TEXEL_BITS-1:0]   texel;
	} stexr_job_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} stexr_hs_t;

	function automatic logic [PHASE_BITS-1:0] swirl_phase(
		input logic [SIDE_BITS-1:0] coord,
		input int unsigned          cmul,
		input logic [TIME_BITS-1:0] t,
		input int unsigned          tmul,
		input int unsigned          ofs
	);
		swirl_phase = PHASE_BITS'(32'(coord) * cmul + 32'(t) * tmul + ofs);
	endfunction

	function automatic logic signed [1:0] swirl_quant(input logic [PHASE_BITS-1:0] k);
		if (k < PHASE_BITS'(Q_RISE))
			swirl_quant = 2'sd0;
		else if (k <= PHASE_BITS'(Q_PEAK_END))
			swirl_quant = 2'sd1;
		else if (k <= PHASE_BITS'(Q_HALF_END))
			swirl_quant = 2'sd0;
		else if (k <= PHASE_BITS'(Q_FALL_END))
			swirl_quant = -2'sd1;
		else if (k <= PHASE_BITS'(Q_TROUGH_END))
			swirl_quant = -2'sd2;
		else
			swirl_quant = -2'sd1;
	endfunction
endpackage
`default_nettype wire

[hdl/stexr_stream_if.sv]
// Stream interfaces: command beats in, fetched pixel beats out.
`default_nettype none
interface stexr_in_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [stexr_pkg::INDEX_BITS-1:0]  pixel_index;
	logic [stexr_pkg::VALUE_BITS-1:0]  texel_value;
	logic [stexr_pkg::TIME_BITS-1:0]   frame_time;

	modport source (output valid, op, pixel_index, texel_value, frame_time, input ready);
	modport sink   (input valid, op, pixel_index, texel_value, frame_time, output ready);
endinterface

interface stexr_out_if;
	logic                              valid;
	logic                              ready;
	logic [stexr_pkg::VALUE_BITS-1:0]  pixel_value;
	logic [stexr_pkg::INDEX_BITS-1:0]  source_index;

	modport source (output valid, pixel_value, source_index, input ready);
	modport sink   (input valid, pixel_value, source_index, output ready);
endinterface
`default_nettype wire

[hdl/stexr_front.sv]
// Front end: accepts command beats, computes swirl phases, emits store jobs.
`default_nettype none
`include "swirl_texture_remap_core_defines.svh"
module stexr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	stexr_in_if.sink               cmd,
	output stexr_pkg::stexr_hs_t   push_hs,
	input  wire logic              push_ready,
	output stexr_pkg::stexr_job_t  push_job
);
	import stexr_pkg::*;

	logic                    v_s1;
	stexr_op_t               op_s1;
	logic [INDEX_BITS-1:0]   idx_s1;
	logic [TEXEL_BITS-1:0]   texel_s1;
	logic [PHASE_BITS-1:0]   ph_a_s1, ph_b_s1, ph_c_s1, ph_d_s1;

	logic [SIDE_BITS-1:0]    cx, cy, sx, sy;
	logic [TIME_BITS-1:0]    t_red;
	logic signed [1:0]       qa, qb, qc, qd;
	logic [7:0]              ox, oy;
	logic                    take;

	assign cmd.ready = !v_s1 || push_ready;
	assign take      = cmd.valid && cmd.ready;

	assign cx    = cmd.pixel_index[SIDE_BITS-1:0];
	assign cy    = cmd.pixel_index[INDEX_BITS-1:SIDE_BITS];
	assign t_red = TIME_BITS'(32'(cmd.frame_time) % ANIM_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= stexr_op_t'(cmd.op);
			idx_s1   <= cmd.pixel_index;
			texel_s1 <= TEXEL_BITS'(cmd.texel_value);
			ph_a_s1  <= swirl_phase(cy, COORD_MUL_LO, t_red, TMUL_A,  OFS_A);
			ph_b_s1  <= swirl_phase(cx, COORD_MUL_HI, t_red, TMUL_BD, OFS_B);
			ph_c_s1  <= swirl_phase(cx, COORD_MUL_LO, t_red, TMUL_C,  OFS_C);
			ph_d_s1  <= swirl_phase(cy, COORD_MUL_HI, t_red, TMUL_BD, OFS_D);
		end
	end

	// quantize and fold in the offsets; the bias wraps away mod 64 but is kept explicit
	always_comb begin
		qa = swirl_quant(ph_a_s1);
		qb = swirl_quant(ph_b_s1);
		qc = swirl_quant(ph_c_s1);
		qd = swirl_quant(ph_d_s1);
		ox = 8'(idx_s1[SIDE_BITS-1:0]) + 8'(SWIRL_BIAS)
			+ {{6{qa[1]}}, qa} + {{6{qb[1]}}, qb};
		oy = 8'(idx_s1[INDEX_BITS-1:SIDE_BITS]) + 8'(SWIRL_BIAS)
			+ {{6{qc[1]}}, qc} + {{6{qd[1]}}, qd};
		sx = ox[SIDE_BITS-1:0];
		sy = oy[SIDE_BITS-1:0];
	end

	always_comb begin
		push_hs.valid  = v_s1;
		push_hs.ready  = push_ready;
		push_job.op    = op_s1;
		push_job.texel = texel_s1;
		push_job.addr  = (op_s1 == OP_READ) ? {sy, sx} : idx_s1;
	end

	`STEXR_ASSERT(a_hold_stage, v_s1 && !push_ready |=> v_s1 && $stable(idx_s1))
	`STEXR_ASSERT(a_take_fills, take |=> v_s1)
	`STEXR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !v_s1)
endmodule
`default_nettype wire

[hdl/stexr_queue.sv]
// Short job queue between front end and store back end.
`default_nettype none
`include "swirl_texture_remap_core_defines.svh"
module stexr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  stexr_pkg::stexr_hs_t   push_hs,
	output logic                   push_ready,
	input  stexr_pkg::stexr_job_t  push_job,
	output logic                   pop_valid,
	input  wire logic              pop_en,
	output stexr_pkg::stexr_job_t  pop_job
);
	import stexr_pkg::*;

	stexr_job_t              slot_q [QDEPTH];
	logic [QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]    cnt_q;
	logic                    push, pop;

	assign push_ready = (cnt_q != QCNT_BITS'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_hs.valid && push_hs.ready;
	assign pop        = pop_en && pop_valid;
	assign pop_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	`STEXR_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCNT_BITS'(QDEPTH))
	`STEXR_ASSERT(a_pop_nonempty, pop_en && !pop_valid |=> $stable(rd_ptr_q))
	`STEXR_ASSERT(a_cnt_track, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
endmodule
`default_nettype wire

[hdl/stexr_back.sv]
// Back end: texel store with registered read and the result register.
`default_nettype none
`include "swirl_texture_remap_core_defines.svh"
module stexr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_en,
	input  stexr_pkg::stexr_job_t  pop_job,
	stexr_out_if.source            result
);
	import stexr_pkg::*;

	logic [TEXEL_BITS-1:0]   store [STORE_DEPTH];
	logic [TEXEL_BITS-1:0]   rd_q;
	logic [INDEX_BITS-1:0]   src_q;
	logic                    out_valid_q;
	logic                    pop;

	// take a job when the result slot is empty or drains this cycle
	assign pop_en = !out_valid_q || result.ready;
	assign pop    = pop_en && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_en) begin
			out_valid_q <= pop && (pop_job.op == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_job.op == OP_WRITE)
			store[pop_job.addr] <= pop_job.texel;
		if (pop && pop_job.op == OP_READ) begin
			rd_q  <= store[pop_job.addr];
			src_q <= pop_job.addr;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pixel_value  = VALUE_BITS'(rd_q);
	assign result.source_index = src_q;

	`STEXR_ASSERT(a_read_yields, pop && pop_job.op == OP_READ |=> out_valid_q)
	`STEXR_ASSERT(a_write_silent, pop && pop_job.op == OP_WRITE |=> !out_valid_q)
	`STEXR_ASSERT(a_stall_hold, out_valid_q && !result.ready |=> out_valid_q && $stable(src_q))
endmodule
`default_nettype wire

[hdl/swirl_texture_remap_core.sv]
// A read beat passes the phase stage, a queue slot and the result register.
// Throughput: one beat per cycle unless the result stalls; writes give no result.
// The rate is set by the single store port: one access per write or swirled read.
// Reset (arst_n low, async) empties the phase stage, job queue and result register;
// the texel store is not cleared and holds garbage until each texel is written.
`default_nettype none
module swirl_texture_remap_core (
	input  wire logic clk,
	input  wire logic arst_n,
	stexr_in_if.sink  cmd,
	stexr_out_if.source result
);
	import stexr_pkg::*;

	// front -> queue
	stexr_hs_t   push_hs;
	logic        push_ready;
	stexr_job_t  push_job;

	// queue -> back
	logic        pop_valid;
	logic        pop_en;
	stexr_job_t  pop_job;

	// Front: register the beat and its four swirl phases, then quantize them
	// into a source address (reads) or pass the slot through (writes).
	stexr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_hs    (push_hs),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Four-deep queue decouples address generation from store access, so a
	// stalled result does not immediately back up the command side.
	stexr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_hs    (push_hs),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_en     (pop_en),
		.pop_job    (pop_job)
	);

	// Back: one store access per job; read data lands in the result register,
	// which holds while the result beat is stalled.
	stexr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_en    (pop_en),
		.pop_job   (pop_job),
		.result    (result)
	);
endmodule
`default_nettype wire
